// ===== hw/rtl/lsfs_pkg.sv =====
package lsfs_pkg;

    // Field widths fixed by the stream formats.
    localparam int ID_W     = 7;
    localparam int SID_W    = 4;
    localparam int KEY_W    = 8;
    localparam int TOT_W    = 32;
    localparam int WAIT_W   = 5;
    localparam int SEAT_W   = 5;
    localparam int LIM_W    = 8;
    localparam int NREQ_W   = 7;
    localparam int STAT_W   = 3;
    localparam int CFG_IX_W = 2;
    localparam int CFG_D_W  = 8;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 88;

    // Default sizes.
    localparam int DEF_QUEUE_DEPTH    = 16;
    localparam int DEF_MAX_REQUESTERS = 64;
    localparam int DEF_MAX_SERVERS    = 8;

    // Register reset values.
    localparam logic [SEAT_W-1:0] SEAT_RST = 5'd4;
    localparam logic [LIM_W-1:0]  LIM_RST  = 8'd3;
    localparam logic [NREQ_W-1:0] NREQ_RST = 7'd64;

    // Register indexes.
    localparam logic [CFG_IX_W-1:0] CFG_SEAT_COUNT      = 2'd0;
    localparam logic [CFG_IX_W-1:0] CFG_SERVICE_LIMIT   = 2'd1;
    localparam logic [CFG_IX_W-1:0] CFG_REQUESTER_COUNT = 2'd2;

    // Request kinds.
    localparam logic REQ_ARRIVE = 1'b0;
    localparam logic REQ_SERVE  = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_SEATED  = 3'd0,
        ST_NO_SEAT = 3'd1,
        ST_REFUSED = 3'd2,
        ST_WAITING = 3'd3,
        ST_SERVED  = 3'd4,
        ST_EMPTY   = 3'd5
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

// ===== hw/rtl/lsfs_ctrl.sv =====
module lsfs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  lsfs_pkg::t_sts   i_sts,
    output logic             o_in_ready,
    output lsfs_pkg::t_cmd   o_cmd
);
    import lsfs_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state: take a request, then finish it once the output register is free.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_EXEC: begin
                o_cmd.exec = i_sts.out_free;
            end
            default: ;
        endcase
    end

endmodule

// ===== hw/rtl/lsfs_dp.sv =====
module lsfs_dp #(
    parameter int QUEUE_DEPTH    = lsfs_pkg::DEF_QUEUE_DEPTH,
    parameter int MAX_REQUESTERS = lsfs_pkg::DEF_MAX_REQUESTERS,
    parameter int MAX_SERVERS    = lsfs_pkg::DEF_MAX_SERVERS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  lsfs_pkg::t_cmd                       i_cmd,
    output lsfs_pkg::t_sts                       o_sts,
    input  logic [lsfs_pkg::IN_TDATA_W-1:0]      i_in_data,
    input  logic                                 i_in_type,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [lsfs_pkg::CFG_IX_W-1:0]        i_cfg_index,
    input  logic [lsfs_pkg::CFG_D_W-1:0]         i_cfg_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [lsfs_pkg::OUT_TDATA_W-1:0]     o_out_data,
    output logic [lsfs_pkg::STAT_W-1:0]          o_out_status
);
    import lsfs_pkg::*;

    localparam int AW = (MAX_REQUESTERS > 1) ? $clog2(MAX_REQUESTERS) : 1;
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [8:0] MAXR = 9'(MAX_REQUESTERS);
    localparam logic [6:0] MAXQ = 7'(QUEUE_DEPTH);
    localparam logic [6:0] MAXS = 7'(MAX_SERVERS);

    // Configuration registers.
    logic [SEAT_W-1:0] r_seat;
    logic [LIM_W-1:0]  r_limit;
    logic [NREQ_W-1:0] r_nreq;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seat  <= SEAT_RST;
            r_limit <= LIM_RST;
            r_nreq  <= NREQ_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SEAT_COUNT:      r_seat  <= i_cfg_data[SEAT_W-1:0];
                CFG_SERVICE_LIMIT:   r_limit <= i_cfg_data[LIM_W-1:0];
                CFG_REQUESTER_COUNT: r_nreq  <= i_cfg_data[NREQ_W-1:0];
                default: ;
            endcase
        end
    end

    // Seat row: sorted shift-insert queue.
    logic [ID_W-1:0]  r_ids  [QUEUE_DEPTH];
    logic [KEY_W-1:0] r_keys [QUEUE_DEPTH];
    logic [ID_W-1:0]  n_ids  [QUEUE_DEPTH];
    logic [KEY_W-1:0] n_keys [QUEUE_DEPTH];
    logic [FW-1:0]    r_fill;
    logic [FW-1:0]    n_fill;

    // Latched request.
    logic             r_type;
    logic [ID_W-1:0]  r_rid;
    logic [SID_W-1:0] r_sid;
    logic [AW-1:0]    r_idx;

    // Service count memory with valid bits, and waiting flags.
    logic [KEY_W-1:0]          mem_cnt [MAX_REQUESTERS];
    logic [MAX_REQUESTERS-1:0] r_vld;
    logic [MAX_REQUESTERS-1:0] r_flg;
    logic [KEY_W-1:0]          r_mem_q;
    logic                      r_vld_q;

    logic [TOT_W-1:0] r_req_tot;
    logic [TOT_W-1:0] r_ses_tot;

    // Output register.
    logic                  r_out_valid;
    t_status               r_out_status;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic [ID_W-1:0]  in_rid;
    logic [SID_W-1:0] in_sid;
    logic [AW-1:0]    ld_idx;

    assign in_rid = i_in_data[ID_W-1:0];
    assign in_sid = i_in_data[ID_W+SID_W-1:ID_W];

    // Table address: the arriving id, or the head of the row for a server.
    always_comb begin
        if (i_in_type == REQ_SERVE) begin
            ld_idx = AW'(ID_W'(r_ids[0] - ID_W'(1)));
        end else begin
            ld_idx = AW'(ID_W'(in_rid - ID_W'(1)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_type  <= i_in_type;
            r_rid   <= in_rid;
            r_sid   <= in_sid;
            r_idx   <= ld_idx;
            r_mem_q <= mem_cnt[ld_idx];
            r_vld_q <= r_vld[ld_idx];
        end
    end

    // Decision logic.
    logic [KEY_W-1:0] cnt;
    logic [KEY_W-1:0] cnt_inc;
    logic [8:0]       nreq_eff;
    logic [6:0]       seats_eff;
    logic             do_seat;
    logic             do_serve;
    t_status          st;
    logic [ID_W-1:0]  who;
    logic [SID_W-1:0] srv;
    logic [KEY_W-1:0] pri;
    logic [QUEUE_DEPTH-1:0] gt;
    logic [QUEUE_DEPTH-1:0] gt_prev;

    assign cnt     = r_vld_q ? r_mem_q : '0;
    assign cnt_inc = (cnt == '1) ? cnt : KEY_W'(cnt + KEY_W'(1));

    always_comb begin
        nreq_eff  = ({2'b0, r_nreq} < MAXR) ? {2'b0, r_nreq} : MAXR;
        seats_eff = ({2'b0, r_seat} < MAXQ) ? {2'b0, r_seat} : MAXQ;
        do_seat   = 1'b0;
        do_serve  = 1'b0;
        who       = '0;
        srv       = '0;
        pri       = '0;
        if (r_type == REQ_ARRIVE) begin
            priority if (r_rid == '0 || {2'b0, r_rid} > nreq_eff) begin
                st = ST_REFUSED;
            end else if (cnt >= r_limit) begin
                st = ST_REFUSED;
            end else if (r_flg[r_idx]) begin
                st = ST_WAITING;
            end else if (7'(r_fill) >= seats_eff) begin
                st = ST_NO_SEAT;
            end else begin
                st      = ST_SEATED;
                do_seat = 1'b1;
                who     = r_rid;
                pri     = cnt;
            end
        end else begin
            priority if (r_sid == '0 || 7'(r_sid) > MAXS) begin
                st = ST_REFUSED;
            end else if (r_fill == '0) begin
                st = ST_EMPTY;
            end else begin
                st       = ST_SERVED;
                do_serve = 1'b1;
                who      = r_ids[0];
                srv      = r_sid;
                pri      = cnt;
            end
        end
    end

    // Per-seat compare: waiting entries with a larger key move back.
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            gt[i] = (FW'(i) < r_fill) && (r_keys[i] > cnt);
        end
        gt_prev = {gt[QUEUE_DEPTH-2:0], 1'b0};
    end

    // Next row contents.
    always_comb begin
        n_fill = r_fill;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            n_ids[i]  = r_ids[i];
            n_keys[i] = r_keys[i];
            if (i_cmd.exec && do_seat && (gt[i] || FW'(i) == r_fill)) begin
                if (gt_prev[i] && i > 0) begin
                    n_ids[i]  = r_ids[i-1];
                    n_keys[i] = r_keys[i-1];
                end else begin
                    n_ids[i]  = r_rid;
                    n_keys[i] = cnt;
                end
            end else if (i_cmd.exec && do_serve && i < QUEUE_DEPTH - 1) begin
                n_ids[i]  = r_ids[i+1];
                n_keys[i] = r_keys[i+1];
            end
        end
        if (do_seat) begin
            n_fill = FW'(r_fill + FW'(1));
        end else if (do_serve) begin
            n_fill = FW'(r_fill - FW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            r_ids[i]  <= n_ids[i];
            r_keys[i] <= n_keys[i];
        end
    end

    // Service count memory write.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && do_serve) begin
            mem_cnt[r_idx] <= cnt_inc;
        end
    end

    // Control state: fill, valid bits, waiting flags and tallies.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_vld     <= '0;
            r_flg     <= '0;
            r_req_tot <= '0;
            r_ses_tot <= '0;
        end else if (i_cmd.exec) begin
            r_fill <= n_fill;
            if (do_seat) begin
                r_flg[r_idx] <= 1'b1;
                r_req_tot    <= r_req_tot + TOT_W'(1);
            end
            if (do_serve) begin
                r_flg[r_idx] <= 1'b0;
                r_vld[r_idx] <= 1'b1;
                r_ses_tot    <= r_ses_tot + TOT_W'(1);
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out_status <= st;
            r_out_data   <= {
                (do_serve ? r_ses_tot + TOT_W'(1) : r_ses_tot),
                (do_seat  ? r_req_tot + TOT_W'(1) : r_req_tot),
                WAIT_W'(n_fill),
                pri,
                srv,
                who
            };
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out_data;
    assign o_out_status   = r_out_status;

endmodule

// ===== hw/rtl/least_served_first_seat_scheduler_top.sv =====
// Channel   Direction  Handshake              Payload
// s_axis    in         tvalid / tready        tdata: requester_id, server_id; tuser: req_type
// m_axis    out        tvalid / tready        tdata: result fields; tuser: status
// cfg       in         valid / ready          index, data (always ready)
//
// A request is taken in the idle state, which reads the service count table; the exec
// state then decides, updates the seat row and loads the result register.
// The result register lets a new request be taken while a result waits;
// a request finishes only once that register is free.
// Reset is synchronous and active low; it clears counts, flags and tallies.
module least_served_first_seat_scheduler_top #(
    parameter int QUEUE_DEPTH    = lsfs_pkg::DEF_QUEUE_DEPTH,
    parameter int MAX_REQUESTERS = lsfs_pkg::DEF_MAX_REQUESTERS,
    parameter int MAX_SERVERS    = lsfs_pkg::DEF_MAX_SERVERS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // requester_id [6:0], server_id [10:7], zero [15:11]
    input  logic [lsfs_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // req_type [0]
    input  logic                                i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // chosen_requester [6:0], serving_server [10:7], priority_value [18:11],
    // waiting_now [23:19], requests_total [55:24], sessions_total [87:56]
    output logic [lsfs_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    // status [2:0]
    output logic [lsfs_pkg::STAT_W-1:0]         o_m_axis_tuser,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lsfs_pkg::CFG_IX_W-1:0]       i_cfg_index,
    input  logic [lsfs_pkg::CFG_D_W-1:0]        i_cfg_data
);
    import lsfs_pkg::*;

    t_cmd cmd;
    t_sts sts;

    lsfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_sts      (sts),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (cmd)
    );

    lsfs_dp #(
        .QUEUE_DEPTH    (QUEUE_DEPTH),
        .MAX_REQUESTERS (MAX_REQUESTERS),
        .MAX_SERVERS    (MAX_SERVERS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_in_data    (i_s_axis_tdata),
        .i_in_type    (i_s_axis_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_out_valid  (o_m_axis_tvalid),
        .i_out_ready  (i_m_axis_tready),
        .o_out_data   (o_m_axis_tdata),
        .o_out_status (o_m_axis_tuser)
    );

    // A taken request blocks the input for the following cycle.
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input ready right after a request was taken");

    // A served result names a requester and a server.
    a_served_ids: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == ST_SERVED |->
            o_m_axis_tdata[6:0] != '0 && o_m_axis_tdata[10:7] != '0)
        else $error("served result without requester or server");

    // A seated result names a requester and no server.
    a_seated_ids: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == ST_SEATED |->
            o_m_axis_tdata[6:0] != '0 && o_m_axis_tdata[10:7] == '0)
        else $error("seated result with bad ids");

    // The waiting count never exceeds the row.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> 7'(o_m_axis_tdata[23:19]) <= 7'(QUEUE_DEPTH))
        else $error("waiting count above row depth");

endmodule

// ===== tb/sv/least_served_first_seat_scheduler_top_test.sv =====
module least_served_first_seat_scheduler_top_test;
    import lsfs_pkg::*;

    localparam int QDEPTH    = DEF_QUEUE_DEPTH;
    localparam int NREQ_MAX  = DEF_MAX_REQUESTERS;
    localparam int NSRV_MAX  = DEF_MAX_SERVERS;
    localparam int CYCLE_CAP = 400000;

    // One request as offered on the input stream.
    typedef struct packed {
        logic              kind;
        logic [ID_W-1:0]   rid;
        logic [SID_W-1:0]  sid;
    } t_sched_req;

    // One scheduling outcome as carried on the output stream.
    typedef struct packed {
        t_status           st;
        logic [ID_W-1:0]   who;
        logic [SID_W-1:0]  srv;
        logic [KEY_W-1:0]  pri;
        logic [WAIT_W-1:0] wnow;
        logic [TOT_W-1:0]  rq_tot;
        logic [TOT_W-1:0]  ss_tot;
    } t_sched_res;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata;
    logic                   i_s_axis_tuser;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic [STAT_W-1:0]      o_m_axis_tuser;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IX_W-1:0]    i_cfg_index;
    logic [CFG_D_W-1:0]     i_cfg_data;

    least_served_first_seat_scheduler_top DUT (.*);

    // Shadow of the scheduler state.
    logic [ID_W-1:0]  seat_ids  [QDEPTH];
    logic [KEY_W-1:0] seat_keys [QDEPTH];
    int unsigned      seat_fill;
    logic [KEY_W-1:0] served_cnt [NREQ_MAX];
    bit               is_waiting [NREQ_MAX];
    logic [TOT_W-1:0] arrivals_tot;
    logic [TOT_W-1:0] sessions_tot;
    logic [SEAT_W-1:0] seat_reg;
    logic [LIM_W-1:0]  limit_reg;
    logic [NREQ_W-1:0] nreq_reg;

    t_sched_req pending_reqs [$];
    t_sched_res expected_res [$];
    t_sched_req cur_req;

    bit  drv_valid, in_taken, burst, choke_done;
    int  gap_left, stall_left, choke_left;
    int  out_count, errors, cycles;

    // Work out the outcome of one request and advance the shadow state.
    function automatic t_sched_res schedule(t_sched_req r);
        t_sched_res res;
        int unsigned nreq, seats, pos, idx;
        logic [KEY_W-1:0] key;
        res = '{ST_REFUSED, '0, '0, '0, '0, '0, '0};
        nreq  = (nreq_reg < NREQ_MAX) ? nreq_reg : NREQ_MAX;
        seats = (seat_reg < QDEPTH) ? seat_reg : QDEPTH;
        if (r.kind == REQ_ARRIVE) begin
            if (r.rid != 0 && r.rid <= nreq) begin
                idx = r.rid - 1;
                key = served_cnt[idx];
                if (key >= limit_reg) res.st = ST_REFUSED;
                else if (is_waiting[idx]) res.st = ST_WAITING;
                else if (seat_fill >= seats) res.st = ST_NO_SEAT;
                else begin
                    // Seat after every requester with a key at or below this one.
                    pos = 0;
                    while (pos < seat_fill && seat_keys[pos] <= key) pos++;
                    for (int i = seat_fill; i > pos; i--) begin
                        seat_ids[i]  = seat_ids[i-1];
                        seat_keys[i] = seat_keys[i-1];
                    end
                    seat_ids[pos]  = r.rid;
                    seat_keys[pos] = key;
                    seat_fill++;
                    is_waiting[idx] = 1;
                    arrivals_tot++;
                    res.st  = ST_SEATED;
                    res.who = r.rid;
                    res.pri = key;
                end
            end
        end else if (r.sid != 0 && r.sid <= NSRV_MAX) begin
            if (seat_fill == 0) res.st = ST_EMPTY;
            else begin
                res.who = seat_ids[0];
                for (int i = 1; i < seat_fill; i++) begin
                    seat_ids[i-1]  = seat_ids[i];
                    seat_keys[i-1] = seat_keys[i];
                end
                seat_fill--;
                idx = (res.who - 1) % NREQ_MAX;
                res.pri = served_cnt[idx];
                if (served_cnt[idx] != 8'hFF) served_cnt[idx]++;
                is_waiting[idx] = 0;
                sessions_tot++;
                res.st  = ST_SERVED;
                res.srv = r.sid;
            end
        end
        res.wnow   = seat_fill[WAIT_W-1:0];
        res.rq_tot = arrivals_tot;
        res.ss_tot = sessions_tot;
        return res;
    endfunction

    // Clock.
    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Input driver: one request at a time from the pending queue.
    always @(negedge i_clk) begin
        bit nxt;
        nxt = drv_valid;
        if (in_taken) begin
            in_taken = 0;
            nxt = 0;
            if ($urandom_range(0, 99) == 0) burst = !burst;
            gap_left = burst ? 0 : $urandom_range(0, 3);
        end
        if (!nxt && i_rst_n) begin
            if (gap_left > 0) gap_left--;
            else if (pending_reqs.size() > 0) begin
                cur_req = pending_reqs.pop_front();
                i_s_axis_tdata <= {5'b0, cur_req.sid, cur_req.rid};
                i_s_axis_tuser <= cur_req.kind;
                nxt = 1;
            end
        end
        drv_valid = nxt;
        i_s_axis_tvalid <= nxt;
    end

    // Receiver: random stalls per result and one long hold-off.
    always @(negedge i_clk) begin
        if (!choke_done && out_count >= 200) begin
            choke_done = 1;
            choke_left = 300;
        end
        if (choke_left > 0) begin
            choke_left--;
            i_m_axis_tready <= 0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_m_axis_tready <= 0;
        end else begin
            i_m_axis_tready <= 1;
        end
    end

    // Prediction on accepted requests and checking of accepted results.
    always @(posedge i_clk) begin
        t_sched_res got, exp_r;
        cycles++;
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            expected_res.push_back(schedule(cur_req));
            in_taken = 1;
        end
        if (o_m_axis_tvalid && i_m_axis_tready) begin
            got.st     = t_status'(o_m_axis_tuser);
            got.who    = o_m_axis_tdata[6:0];
            got.srv    = o_m_axis_tdata[10:7];
            got.pri    = o_m_axis_tdata[18:11];
            got.wnow   = o_m_axis_tdata[23:19];
            got.rq_tot = o_m_axis_tdata[55:24];
            got.ss_tot = o_m_axis_tdata[87:56];
            out_count++;
            stall_left = burst ? 0 : $urandom_range(0, 3);
            if (expected_res.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result: %p", got);
            end else begin
                exp_r = expected_res.pop_front();
                if (got.st !== exp_r.st || got.who !== exp_r.who || got.srv !== exp_r.srv
                        || got.pri !== exp_r.pri || got.wnow !== exp_r.wnow
                        || got.rq_tot !== exp_r.rq_tot || got.ss_tot !== exp_r.ss_tot) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch at result %0d: expected %p, got %p",
                                 out_count, exp_r, got);
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        if (cycles > CYCLE_CAP) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic add_req(logic kind, int rid, int sid);
        t_sched_req r;
        r.kind = kind;
        r.rid  = rid[ID_W-1:0];
        r.sid  = sid[SID_W-1:0];
        pending_reqs.push_back(r);
    endtask

    // Mostly well-formed traffic within the active ids, some noise.
    task automatic add_random(int count, int nreq);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 9) == 0)
                add_req(1'($urandom_range(0, 1)), $urandom_range(0, 127),
                        $urandom_range(0, 15));
            else if ($urandom_range(0, 99) < 55)
                add_req(REQ_ARRIVE, $urandom_range(1, nreq), $urandom_range(0, 15));
            else
                add_req(REQ_SERVE, $urandom_range(0, 127), $urandom_range(1, NSRV_MAX));
        end
    endtask

    // Let every queued request finish before touching the registers.
    task automatic drain();
        wait (pending_reqs.size() == 0 && !drv_valid && expected_res.size() == 0);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IX_W-1:0] ix, logic [CFG_D_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_index <= ix;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (ix == CFG_SEAT_COUNT) seat_reg = val[SEAT_W-1:0];
        else if (ix == CFG_SERVICE_LIMIT) limit_reg = val;
        else if (ix == CFG_REQUESTER_COUNT) nreq_reg = val[NREQ_W-1:0];
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    task automatic set_regs(int seats, int lim, int nreq);
        drain();
        write_reg(CFG_SEAT_COUNT, seats[7:0]);
        write_reg(CFG_SERVICE_LIMIT, lim[7:0]);
        write_reg(CFG_REQUESTER_COUNT, nreq[7:0]);
    endtask

    // Stimulus sequence.
    initial begin
        i_rst_n = 0;
        i_s_axis_tvalid = 0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = 0;
        i_m_axis_tready = 0;
        i_cfg_valid = 0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        seat_fill = 0;
        arrivals_tot = '0;
        sessions_tot = '0;
        seat_reg = SEAT_RST;
        limit_reg = LIM_RST;
        nreq_reg = NREQ_RST;
        foreach (served_cnt[i]) begin
            served_cnt[i] = '0;
            is_waiting[i] = 0;
        end
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Directed: bad ids, bad servers, empty row, full row, ordering by count.
        add_req(REQ_ARRIVE, 0, 15);
        add_req(REQ_ARRIVE, 127, 0);
        add_req(REQ_ARRIVE, 65, 0);
        add_req(REQ_SERVE, 0, 3);
        add_req(REQ_SERVE, 0, 0);
        add_req(REQ_SERVE, 127, 15);
        add_req(REQ_SERVE, 0, 9);
        add_req(REQ_ARRIVE, 1, 0);
        add_req(REQ_ARRIVE, 64, 0);
        add_req(REQ_ARRIVE, 1, 0);
        add_req(REQ_ARRIVE, 2, 0);
        add_req(REQ_ARRIVE, 3, 0);
        add_req(REQ_ARRIVE, 4, 0);
        add_req(REQ_SERVE, 0, 1);
        add_req(REQ_SERVE, 0, 8);
        add_req(REQ_ARRIVE, 1, 0);
        add_req(REQ_ARRIVE, 5, 0);
        add_req(REQ_SERVE, 0, 2);
        add_req(REQ_SERVE, 0, 3);
        add_req(REQ_SERVE, 0, 4);
        add_req(REQ_SERVE, 0, 5);
        add_req(REQ_SERVE, 0, 6);

        set_regs(16, 255, 64);
        add_random(500, 64);
        set_regs(3, 5, 5);
        add_random(300, 5);
        set_regs(31, 255, 127);
        add_random(250, 64);
        set_regs(1, 2, 1);
        add_random(80, 1);
        set_regs(16, 2, 8);
        add_random(120, 8);
        // Fill the row, then shrink the seats under the waiting requesters.
        set_regs(12, 255, 64);
        for (int k = 10; k < 22; k++) add_req(REQ_ARRIVE, k, 0);
        set_regs(0, 255, 64);
        add_random(60, 64);
        set_regs(2, 0, 64);
        add_random(50, 64);
        set_regs(16, 255, 64);
        add_random(150, 64);

        drain();
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
